FILE: rtl/core/vgp_pkg.sv
// ----------------------------------------------------------------------------
// vgp_pkg
// Shared widths, fixed-point constants and register indexes for the
// per-pixel vignette gain block.
// ----------------------------------------------------------------------------
package vgp_pkg;

    localparam int COORD_W = 12;
    localparam int CH_W    = 8;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_COLS_DEF = 4096;
    localparam int MAX_ROWS_DEF = 4096;

    localparam logic [11:0] RADIUS_RST = 12'd256;
    localparam logic [11:0] CENTER_X_RST = 12'd320;
    localparam logic [11:0] CENTER_Y_RST = 12'd240;

    // Cosine approximation constants, all scaled by 2^16.
    localparam logic [20:0] Q_P2     = 21'd102944;
    localparam logic [20:0] Q_PI     = 21'd205887;
    localparam logic [20:0] Q_TWO_PI = 21'd411775;
    localparam logic [16:0] Q_KA     = 17'd83443;
    localparam logic [14:0] Q_KB     = 15'd26561;

    localparam int RATIO_W = 20;
    localparam int GAIN_W  = 18;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS   = 2'd0,
        CFG_CENTER_X = 2'd1,
        CFG_CENTER_Y = 2'd2,
        CFG_MODE     = 2'd3
    } t_cfg_idx;

endpackage

FILE: rtl/core/vgp_in_if.sv
// ----------------------------------------------------------------------------
// vgp_in_if
// Input pixel channel: coordinates and RGB channels with valid/ready.
// ----------------------------------------------------------------------------
interface vgp_in_if
    import vgp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  pix_x;
    logic [COORD_W-1:0]  pix_y;
    logic [CH_W-1:0]     in_blue;
    logic [CH_W-1:0]     in_green;
    logic [CH_W-1:0]     in_red;

    modport source (output valid, pix_x, pix_y, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, pix_x, pix_y, in_blue, in_green, in_red, output ready);
endinterface

FILE: rtl/core/vgp_out_if.sv
// ----------------------------------------------------------------------------
// vgp_out_if
// Output pixel channel: RGB channels after the gain, with valid/ready.
// ----------------------------------------------------------------------------
interface vgp_out_if
    import vgp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;

    modport source (output valid, out_blue, out_green, out_red, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, output ready);
endinterface

FILE: rtl/core/vignette_gain_per_pixel.sv
// ----------------------------------------------------------------------------
// vignette_gain_per_pixel
// Per-pixel vignette gain with a parabolic cosine falloff, fully pipelined.
// ----------------------------------------------------------------------------
// The block accepts one pixel transaction per clock while the output is not
// stalled and returns each result in order. The pipeline is built from the
// bit-per-stage square root pipelines (21 stages), the restoring
// ratio divider (20 stages) and the per-channel divider used in remove mode
// (8 stages).
// When the output transaction is not taken the whole pipeline holds, so ready
// on the input drops only while a finished pixel waits at the output.
// Configuration registers may be written only while no pixel is in flight;
// every stage reads the live register values.
// ----------------------------------------------------------------------------
module vignette_gain_per_pixel
    import vgp_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    vgp_in_if.sink               i_pix,
    vgp_out_if.source            o_pix
);

    // Squared distances are exact integers; the square root works on them
    // shifted up by 16 so that the root comes out in Q.8.
    localparam int D2_W     = 2 * COORD_W + 1;
    localparam int SQ_BITS  = (D2_W + 16 + 1) / 2;
    localparam int SQ_W     = 2 * SQ_BITS;
    localparam int MD_W     = CFG_W + SQ_BITS;
    localparam int DN_W     = SQ_BITS + 24 + 1;
    localparam int DIV_BITS = RATIO_W;
    localparam int DT_W     = MD_W + DIV_BITS;
    localparam int CD_BITS  = CH_W;
    localparam int CN_W     = CH_W + 16 + 1;
    localparam int CT_W     = GAIN_W + CD_BITS;
    localparam int PR_W     = CH_W + GAIN_W;

    // Stage positions along the pipe.
    localparam int ST_SQ  = 2;
    localparam int ST_MD  = ST_SQ + SQ_BITS;
    localparam int ST_DP  = ST_MD + 1;
    localparam int ST_DV  = ST_DP + 1;
    localparam int ST_M   = ST_DV + DIV_BITS;
    localparam int ST_CD  = ST_M + 10;
    localparam int ST_OUT = ST_CD + CD_BITS;
    localparam int N_ST   = ST_OUT + 1;

    localparam logic [COORD_W:0]   COL_LIM = (COORD_W+1)'(MAX_COLS);
    localparam logic [COORD_W:0]   ROW_LIM = (COORD_W+1)'(MAX_ROWS);
    localparam logic [COORD_W-1:0] COL_TOP = COORD_W'(MAX_COLS - 1);
    localparam logic [COORD_W-1:0] ROW_TOP = COORD_W'(MAX_ROWS - 1);

    typedef struct packed {
        logic [SQ_W-1:0]    rem;
        logic [SQ_BITS-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [MD_W-1:0]     den;
        logic [DN_W-1:0]     rem;
        logic [DIV_BITS-1:0] quo;
        logic                sat;
    } t_dv;

    typedef struct packed {
        logic [GAIN_W-1:0]  den;
        logic [CN_W-1:0]    rem;
        logic [CD_BITS-1:0] quo;
        logic               sat;
        logic [PR_W-1:0]    prod;
    } t_cd;

    typedef logic [2:0][CH_W-1:0] t_rgb;

    function automatic t_sq sq_step(t_sq s, int unsigned i);
        logic [SQ_W-1:0] trial;
        t_sq             res;
        trial = (SQ_W'(s.root) << (i + 1)) | (SQ_W'(1) << (2 * i));
        res = s;
        if (s.rem >= trial) begin
            res.rem  = s.rem - trial;
            res.root = s.root | (SQ_BITS'(1) << i);
        end
        return res;
    endfunction

    function automatic t_dv dv_step(t_dv s, int unsigned i);
        logic [DT_W-1:0] trial;
        t_dv             res;
        trial = DT_W'(s.den) << i;
        res = s;
        if (DT_W'(s.rem) >= trial) begin
            res.rem = DN_W'(DT_W'(s.rem) - trial);
            res.quo = s.quo | (DIV_BITS'(1) << i);
        end
        return res;
    endfunction

    function automatic t_cd cd_step(t_cd s, int unsigned i);
        logic [CT_W-1:0] trial;
        t_cd             res;
        trial = CT_W'(s.den) << i;
        res = s;
        if (CT_W'(s.rem) >= trial) begin
            res.rem = CN_W'(CT_W'(s.rem) - trial);
            res.quo = s.quo | (CD_BITS'(1) << i);
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                    logic [COORD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0]   r_radius;
    logic [COORD_W-1:0] r_center_x;
    logic [COORD_W-1:0] r_center_y;
    logic               r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RST;
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------- flow control
    // One enable moves every stage; a waiting output freezes the pipe.
    logic            en;
    logic [N_ST-1:0] r_vld;
    t_rgb            r_rgb [0:N_ST-2];

    assign en          = !r_vld[N_ST-1] || o_pix.ready;
    assign i_pix.ready = en;
    assign o_pix.valid = r_vld[N_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_ST-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rgb[0] <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        end
    end

    for (genvar k = 1; k < N_ST - 1; k++) begin : g_rgb
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rgb[k] <= r_rgb[k-1];
            end
        end
    end

    // ------------------------------------------- clamp and absolute offsets
    logic [COORD_W-1:0] w_px, w_py;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [D2_W-1:0]    r_d2, r_c2;

    assign w_px = ({1'b0, i_pix.pix_x} >= COL_LIM) ? COL_TOP : i_pix.pix_x;
    assign w_py = ({1'b0, i_pix.pix_y} >= ROW_LIM) ? ROW_TOP : i_pix.pix_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= abs_diff(w_px, r_center_x);
            r_dy <= abs_diff(w_py, r_center_y);
            r_d2 <= D2_W'((2*COORD_W)'(r_dx) * (2*COORD_W)'(r_dx))
                  + D2_W'((2*COORD_W)'(r_dy) * (2*COORD_W)'(r_dy));
            r_c2 <= D2_W'((2*COORD_W)'(r_center_x) * (2*COORD_W)'(r_center_x))
                  + D2_W'((2*COORD_W)'(r_center_y) * (2*COORD_W)'(r_center_y));
        end
    end

    // ----------------------------------------- square roots, one bit a stage
    t_sq r_sqd [0:SQ_BITS-1];
    t_sq r_sqc [0:SQ_BITS-1];

    for (genvar j = 0; j < SQ_BITS; j++) begin : g_sq
        t_sq w_d_in, w_c_in;
        if (j == 0) begin : g_first
            assign w_d_in = '{rem: SQ_W'({r_d2, 16'b0}), root: '0};
            assign w_c_in = '{rem: SQ_W'({r_c2, 16'b0}), root: '0};
        end else begin : g_next
            assign w_d_in = r_sqd[j-1];
            assign w_c_in = r_sqc[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sqd[j] <= sq_step(w_d_in, SQ_BITS - 1 - j);
                r_sqc[j] <= sq_step(w_c_in, SQ_BITS - 1 - j);
            end
        end
    end

    // ------------------------------------- maximum distance and ratio divide
    logic [MD_W-1:0]    r_md;
    logic [SQ_BITS-1:0] r_sd;
    logic [DN_W-1:0]    w_num;
    t_dv                r_dp;
    t_dv                r_dv [0:DIV_BITS-1];

    assign w_num = (DN_W'(r_sd) << 24) + DN_W'(r_md >> 1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md     <= MD_W'(r_radius) * MD_W'(r_sqc[SQ_BITS-1].root);
            r_sd     <= r_sqd[SQ_BITS-1].root;
            // A quotient of 2^20 or more, or a zero divisor, saturates.
            r_dp.den <= r_md;
            r_dp.rem <= w_num;
            r_dp.quo <= '0;
            r_dp.sat <= (DT_W'(w_num) >= (DT_W'(r_md) << DIV_BITS));
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_dv
        t_dv w_in;
        if (j == 0) begin : g_first
            assign w_in = r_dp;
        end else begin : g_next
            assign w_in = r_dv[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[j] <= dv_step(w_in, DIV_BITS - 1 - j);
            end
        end
    end

    // ------------------------------------------------ cosine and gain square
    logic [RATIO_W-1:0] w_ratio;
    logic [RATIO_W:0]   w_xu;
    logic [RATIO_W-1:0] r_m;
    logic [36:0]        r_ka, r_ka2, r_ka3;
    logic [39:0]        r_mm;
    logic [34:0]        r_kbl, r_kbh;
    logic [54:0]        r_kb, r_mag;
    logic [55:0]        r_s;
    logic [39:0]        w_c;
    logic [GAIN_W-1:0]  r_c;
    logic               r_cbig, r_gsat;
    logic [35:0]        r_cc;
    logic [20:0]        w_gv;
    logic [GAIN_W-1:0]  r_g;

    assign w_ratio = r_dv[DIV_BITS-1].sat ? RATIO_MAX : r_dv[DIV_BITS-1].quo;
    assign w_xu    = (RATIO_W+1)'(w_ratio) + Q_P2;
    assign w_c     = 40'((56'(r_mag) + 56'd32768) >> 16);
    assign w_gv    = 21'((37'(r_cc) + 37'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Shift by pi/2 and wrap once; only the magnitude matters.
            if (w_xu > Q_PI) begin
                r_m <= RATIO_W'((w_xu >= Q_TWO_PI) ? (w_xu - Q_TWO_PI) : (Q_TWO_PI - w_xu));
            end else begin
                r_m <= RATIO_W'(w_xu);
            end
            r_ka   <= 37'(Q_KA) * 37'(r_m);
            r_mm   <= 40'(r_m) * 40'(r_m);
            r_kbl  <= 35'(Q_KB) * 35'(r_mm[19:0]);
            r_kbh  <= 35'(Q_KB) * 35'(r_mm[39:20]);
            r_ka2  <= r_ka;
            r_kb   <= (55'(r_kbh) << 20) + 55'(r_kbl);
            r_ka3  <= r_ka2;
            r_s    <= (56'(r_ka3) << 16) - 56'(r_kb);
            r_mag  <= r_s[55] ? 55'(~r_s + 56'd1) : 55'(r_s);
            r_c    <= w_c[GAIN_W-1:0];
            r_cbig <= |w_c[39:GAIN_W];
            r_cc   <= 36'(r_c) * 36'(r_c);
            r_gsat <= r_cbig;
            r_g    <= (r_gsat || (w_gv > 21'(GAIN_MAX))) ? GAIN_MAX : w_gv[GAIN_W-1:0];
        end
    end

    // ---------------------------------------------- per-channel application
    t_cd r_cd [0:CD_BITS][0:2];

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        logic [CN_W-1:0] w_cn;
        assign w_cn = (CN_W'(r_rgb[ST_CD-2][ch]) << 16) + CN_W'(r_g >> 1);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cd[0][ch].den  <= r_g;
                r_cd[0][ch].rem  <= w_cn;
                r_cd[0][ch].quo  <= '0;
                r_cd[0][ch].sat  <= (CT_W'(w_cn) >= (CT_W'(r_g) << CD_BITS));
                r_cd[0][ch].prod <= PR_W'(r_rgb[ST_CD-2][ch]) * PR_W'(r_g);
            end
        end

        for (genvar j = 0; j < CD_BITS; j++) begin : g_cd
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cd[j+1][ch] <= cd_step(r_cd[j][ch], CD_BITS - 1 - j);
                end
            end
        end
    end

    // ------------------------------------------------------- output register
    t_rgb r_out;

    for (genvar ch = 0; ch < 3; ch++) begin : g_out
        t_cd             w_f;
        logic [PR_W-1:0] w_v;
        assign w_f = r_cd[CD_BITS][ch];
        assign w_v = PR_W'((PR_W'(w_f.prod) + PR_W'(32768)) >> 16);

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_mode) begin
                    r_out[ch] <= (w_v > PR_W'(255)) ? 8'hFF : w_v[CH_W-1:0];
                end else if (w_f.den == '0) begin
                    // Zero gain: a dark channel stays dark, anything else is full.
                    r_out[ch] <= (r_rgb[N_ST-2][ch] == '0) ? 8'h00 : 8'hFF;
                end else begin
                    r_out[ch] <= w_f.sat ? 8'hFF : w_f.quo;
                end
            end
        end
    end

    assign o_pix.out_blue  = r_out[0];
    assign o_pix.out_green = r_out[1];
    assign o_pix.out_red   = r_out[2];

endmodule

FILE: rtl/core/vgp_checker.sv
// ----------------------------------------------------------------------------
// vgp_checker
// Port-level checks of the vignette gain pipeline flow control.
// ----------------------------------------------------------------------------
module vgp_checker
    import vgp_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] i_out_blue,
    input logic [CH_W-1:0] i_out_green,
    input logic [CH_W-1:0] i_out_red
);

    // A stalled result stays and holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_blue)
            && $stable(i_out_green) && $stable(i_out_red))
        else $error("stalled output changed");

    // A stall at the output freezes the pipe, so no new pixel enters.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted during output stall");

    // With no result waiting the block always takes a pixel.
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

endmodule

bind vignette_gain_per_pixel vgp_checker u_vgp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_blue  (o_pix.out_blue),
    .i_out_green (o_pix.out_green),
    .i_out_red   (o_pix.out_red)
);
